[src/bba_pkg.sv]
// Shared types, constants and helpers for the bitmap block allocator.
// No dependencies; imported by bba_ctrl, bba_dp and bitmap_block_allocator.
package bba_pkg;

    localparam int WORD_W = 32;   // bitmap bits per memory word
    localparam int POS_W  = 5;    // bit position within a word
    localparam int BLK_W  = 10;   // block_index / first_free width

    typedef enum logic [1:0] {
        REQ_QUERY = 2'd0,
        REQ_FLIP  = 2'd1,
        REQ_SET   = 2'd2,
        REQ_CLEAR = 2'd3
    } req_kind_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;      // clearing pass: write one bitmap word per cycle
        logic accept;     // latch request, read its bitmap word
        logic upd;        // modify and write bitmap word, read summary word
        logic sum;        // write summary word and top-level flag
        logic find2;      // search top flags, read summary word
        logic find1;      // search summary word, read bitmap word
        logic find0;      // search bitmap word, latch result
        logic load_out;   // move result into output registers
    } bba_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;   // clearing pass at its last word
        logic all_full;   // every block taken
    } bba_stat_t;

    // lowest bit position holding a 0; caller guarantees one exists
    function automatic logic [POS_W-1:0] ff_zero32(input logic [WORD_W-1:0] w);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i])
                pos = POS_W'(i);
        end
        return pos;
    endfunction

endpackage

[src/bitmap_block_allocator.sv]
// Top level of the bitmap free-block allocator.
// Depends on bba_pkg; instantiates bba_ctrl and bba_dp.
//
//  channel | handshake            | beat payload
//  --------+----------------------+---------------------------------------
//  request | in_valid / in_ready  | req_type[1:0], block_index[9:0]
//  result  | out_valid / out_ready| prior_bit, first_free[9:0], full_res
//
// A request steps through accept and bitmap read, read-modify-write, summary
// update and a three-level find-first-zero walk.
// With every block taken the walk stops at the top flags.
// After reset a clearing pass writes one bitmap word per cycle, with in_ready
// low throughout.
// A waiting result holds back only the completion of the next request, not its accept.
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       req_type,
    input  logic [BLK_W-1:0] block_index,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             prior_bit,
    output logic [BLK_W-1:0] first_free,
    output logic             full_res
);

    bba_cmd_t  cmd;
    bba_stat_t stat;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    bba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .block_index (block_index),
        .prior_bit   (prior_bit),
        .first_free  (first_free),
        .full_res    (full_res)
    );

endmodule

[src/bba_ctrl.sv]
// Sequencing state machine for the bitmap block allocator.
// Depends on bba_pkg; drives bba_dp through bba_cmd_t and owns both handshakes.
module bba_ctrl
    import bba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output bba_cmd_t  cmd,
    input  bba_stat_t stat
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_UPD   = 9'b000000100,
        S_SUM   = 9'b000001000,
        S_FIND2 = 9'b000010000,
        S_FIND1 = 9'b000100000,
        S_FIND0 = 9'b001000000,
        S_DONE  = 9'b010000000,
        S_SPARE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.clear    = (state_reg == S_CLEAR);
        cmd.accept   = (state_reg == S_IDLE) && in_valid;
        cmd.upd      = (state_reg == S_UPD);
        cmd.sum      = (state_reg == S_SUM);
        cmd.find2    = (state_reg == S_FIND2);
        cmd.find1    = (state_reg == S_FIND1);
        cmd.find0    = (state_reg == S_FIND0);
        cmd.load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
        unique case (state_reg)
            S_CLEAR: if (stat.clr_last) state_next = S_IDLE;
            S_IDLE:  if (in_valid) state_next = S_UPD;
            S_UPD:   state_next = S_SUM;
            S_SUM:   state_next = S_FIND2;
            S_FIND2: state_next = stat.all_full ? S_DONE : S_FIND1;
            S_FIND1: state_next = S_FIND0;
            S_FIND0: state_next = S_DONE;
            S_DONE:  if (cmd.load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/bba_dp.sv]
// Datapath: bitmap memory, per-word full summary memory, top full flags.
// Depends on bba_pkg; commanded by bba_ctrl.
module bba_dp
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  bba_cmd_t          cmd,
    output bba_stat_t         stat,
    input  logic [1:0]        req_type,
    input  logic [BLK_W-1:0]  block_index,
    output logic              prior_bit,
    output logic [BLK_W-1:0]  first_free,
    output logic              full_res
);

    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int NUM_SUM   = (NUM_WORDS + WORD_W - 1) / WORD_W;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int SUM_AW    = (NUM_SUM > 1) ? $clog2(NUM_SUM) : 1;
    localparam int FOUND_W   = WORD_AW + POS_W;
    localparam int L0_LAST   = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_W;
    localparam int L1_LAST   = NUM_WORDS - (NUM_SUM - 1) * WORD_W;
    // bits past the last real block/word read as taken, so searches skip them
    localparam logic [WORD_W-1:0] L0_PAD =
        (L0_LAST == WORD_W) ? '0 : ~((WORD_W'(1) << L0_LAST) - WORD_W'(1));
    localparam logic [WORD_W-1:0] L1_PAD =
        (L1_LAST == WORD_W) ? '0 : ~((WORD_W'(1) << L1_LAST) - WORD_W'(1));

    logic [WORD_W-1:0]  mem0_reg [NUM_WORDS];
    logic [WORD_W-1:0]  mem1_reg [NUM_SUM];
    logic [WORD_W-1:0]  rd0_data_reg, rd1_data_reg;
    logic [NUM_SUM-1:0] l2_reg;
    logic [WORD_AW-1:0] clr_cnt_reg;

    req_kind_t          kind_reg;
    logic [BLK_W-1:0]   blk_reg;
    logic               word_full_reg;
    logic [SUM_AW-1:0]  sidx_reg;
    logic [WORD_AW-1:0] widx_reg;
    logic               res_prior_reg, res_full_reg;
    logic [FOUND_W-1:0] res_first_reg;
    logic               out_prior_reg, out_full_reg;
    logic [BLK_W-1:0]   out_first_reg;

    logic               in_range;
    logic [WORD_AW-1:0] blk_word;
    logic [SUM_AW-1:0]  blk_sum;
    logic [POS_W-1:0]   blk_pos;
    logic [WORD_W-1:0]  bit_mask, upd_word, sum_word;
    logic [SUM_AW-1:0]  l2_pick;
    logic [WORD_AW-1:0] find_word;
    logic [POS_W-1:0]   pos1, pos0;

    logic               rd0_en, wr0_en, rd1_en, wr1_en;
    logic [WORD_AW-1:0] rd0_addr, wr0_addr;
    logic [SUM_AW-1:0]  rd1_addr, wr1_addr;
    logic [WORD_W-1:0]  wr0_data, wr1_data;

    assign in_range = 32'(blk_reg) < 32'(NUM_BLOCKS);
    assign blk_word = WORD_AW'(blk_reg[BLK_W-1:POS_W]);
    assign blk_sum  = SUM_AW'(blk_word >> POS_W);
    assign blk_pos  = blk_reg[POS_W-1:0];
    assign bit_mask = WORD_W'(1) << blk_pos;

    always_comb
    begin
        unique case (kind_reg)
            REQ_QUERY: upd_word = rd0_data_reg;
            REQ_FLIP:  upd_word = rd0_data_reg ^ bit_mask;
            REQ_SET:   upd_word = rd0_data_reg | bit_mask;
            REQ_CLEAR: upd_word = rd0_data_reg & ~bit_mask;
            default:   upd_word = rd0_data_reg;
        endcase
    end

    always_comb
    begin
        sum_word = rd1_data_reg;
        sum_word[POS_W'(blk_word)] = word_full_reg;
    end

    // first summary word that still has a non-full bitmap word
    always_comb
    begin
        l2_pick = '0;
        for (int i = NUM_SUM - 1; i >= 0; i--) begin
            if (!l2_reg[i])
                l2_pick = SUM_AW'(i);
        end
    end

    assign stat.all_full = &l2_reg;
    assign stat.clr_last = (clr_cnt_reg == WORD_AW'(NUM_WORDS - 1));

    assign pos1      = ff_zero32(rd1_data_reg);
    assign pos0      = ff_zero32(rd0_data_reg);
    assign find_word = WORD_AW'({sidx_reg, pos1});

    // memory port muxing
    always_comb
    begin
        rd0_en   = cmd.accept || cmd.find1;
        rd0_addr = cmd.find1 ? find_word : WORD_AW'(block_index[BLK_W-1:POS_W]);
        wr0_en   = cmd.clear || (cmd.upd && in_range);
        wr0_addr = cmd.clear ? clr_cnt_reg : blk_word;
        wr0_data = cmd.clear ? (stat.clr_last ? L0_PAD : '0) : upd_word;
        rd1_en   = cmd.upd || cmd.find2;
        rd1_addr = cmd.find2 ? l2_pick : blk_sum;
        wr1_en   = (cmd.clear && ({1'b0, clr_cnt_reg} < (WORD_AW + 1)'(NUM_SUM)))
                   || (cmd.sum && in_range);
        wr1_addr = cmd.clear ? SUM_AW'(clr_cnt_reg) : blk_sum;
        wr1_data = cmd.clear ?
                   ((clr_cnt_reg == WORD_AW'(NUM_SUM - 1)) ? L1_PAD : '0) : sum_word;
    end

    always_ff @(posedge clk)
    begin
        if (wr0_en)
            mem0_reg[wr0_addr] <= wr0_data;
        if (rd0_en)
            rd0_data_reg <= mem0_reg[rd0_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr1_en)
            mem1_reg[wr1_addr] <= wr1_data;
        if (rd1_en)
            rd1_data_reg <= mem1_reg[rd1_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l2_reg      <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clear && !stat.clr_last)
                clr_cnt_reg <= clr_cnt_reg + WORD_AW'(1);
            if (cmd.sum && in_range)
                l2_reg[blk_sum] <= &sum_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= req_kind_t'(req_type);
            blk_reg  <= block_index;
        end
        if (cmd.upd)
        begin
            word_full_reg <= &upd_word;
            res_prior_reg <= in_range && rd0_data_reg[blk_pos];
        end
        if (cmd.find2)
        begin
            sidx_reg      <= l2_pick;
            res_full_reg  <= stat.all_full;
            res_first_reg <= '0;
        end
        if (cmd.find1)
            widx_reg <= find_word;
        if (cmd.find0)
            res_first_reg <= {widx_reg, pos0};
        if (cmd.load_out)
        begin
            out_prior_reg <= res_prior_reg;
            out_full_reg  <= res_full_reg;
            out_first_reg <= BLK_W'(res_first_reg);
        end
    end

    assign prior_bit  = out_prior_reg;
    assign first_free = out_first_reg;
    assign full_res   = out_full_reg;

    // a summary word picked from the top flags must hold a non-full word
    a_l1_has_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.find1 |-> !(&rd1_data_reg))
        else $error("summary word chosen by top flags is all full");

    // the bitmap word picked from the summary must hold a free bit
    a_l0_has_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.find0 |-> !(&rd0_data_reg))
        else $error("bitmap word chosen by summary has no free bit");

    // a found block always lies inside the block count
    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.find0 |=> (32'(res_first_reg) < 32'(NUM_BLOCKS)))
        else $error("first free block beyond the block count");

endmodule
